// File: rtl/core/fot_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fot_pkg;

    localparam int ID_W          = 8;
    localparam int ID_RANGE      = 1 << ID_W;
    localparam int NFLAGS        = 4;
    localparam int VALUE_COUNT_D = 256;

    // operation codes
    localparam logic [2:0] OP_NONE    = 3'd0;
    localparam logic [2:0] OP_H2N     = 3'd1;
    localparam logic [2:0] OP_N2H     = 3'd2;
    localparam logic [2:0] OP_BRANCH  = 3'd3;
    localparam logic [2:0] OP_COMBINE = 3'd4;

    // ARM condition codes
    localparam logic [3:0] CC_EQ = 4'd0;
    localparam logic [3:0] CC_NE = 4'd1;
    localparam logic [3:0] CC_CS = 4'd2;
    localparam logic [3:0] CC_CC = 4'd3;
    localparam logic [3:0] CC_MI = 4'd4;
    localparam logic [3:0] CC_PL = 4'd5;
    localparam logic [3:0] CC_VS = 4'd6;
    localparam logic [3:0] CC_VC = 4'd7;
    localparam logic [3:0] CC_HI = 4'd8;
    localparam logic [3:0] CC_LS = 4'd9;
    localparam logic [3:0] CC_GE = 4'd10;
    localparam logic [3:0] CC_LT = 4'd11;
    localparam logic [3:0] CC_GT = 4'd12;
    localparam logic [3:0] CC_LE = 4'd13;

    // one table row: origin and valid bit per flag, index 0 = N .. 3 = V
    typedef struct packed {
        logic [NFLAGS-1:0][ID_W-1:0] org;
        logic [NFLAGS-1:0]           vld;
    } t_entry;

    typedef struct packed {
        logic            en;
        logic [ID_W-1:0] addr;
        t_entry          data;
    } t_wr;

    typedef struct packed {
        logic            new_block;
        logic [2:0]      operation;
        logic [ID_W-1:0] first_value;
        logic [ID_W-1:0] second_value;
        logic [ID_W-1:0] result_value;
        logic [3:0]      condition;
        logic            mask_known;
        logic [3:0]      flag_mask;
    } t_item;

    typedef struct packed {
        logic            rewrite;
        logic [ID_W-1:0] old_value;
        logic [ID_W-1:0] new_value;
    } t_res;

    // flags read by a condition, bit3 = N .. bit0 = V
    function automatic logic [3:0] cond_flags(input logic [3:0] cc);
        logic [3:0] d;
        case (cc)
            CC_EQ, CC_NE: d = 4'b0100;
            CC_CS, CC_CC: d = 4'b0010;
            CC_MI, CC_PL: d = 4'b1000;
            CC_VS, CC_VC: d = 4'b0001;
            CC_HI, CC_LS: d = 4'b0110;
            CC_GE, CC_LT: d = 4'b1001;
            CC_GT, CC_LE: d = 4'b1101;
            default:      d = 4'b0000;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/fot_table.sv
`timescale 1ns / 1ps
`default_nettype none

module fot_table
    import fot_pkg::*;
#(
    parameter int VALUE_COUNT = VALUE_COUNT_D
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_rd_en,
    input  wire logic [ID_W-1:0] i_rd_addr_a,
    input  wire logic [ID_W-1:0] i_rd_addr_b,
    input  wire logic            i_commit,
    input  wire logic            i_clear,
    input  wire t_wr             i_wr,
    output t_entry               o_ent_a,
    output t_entry               o_ent_b
);

    localparam int DEPTH = (VALUE_COUNT < ID_RANGE) ? VALUE_COUNT : ID_RANGE;
    localparam int AW    = $clog2(DEPTH);

    function automatic logic in_rng(input logic [ID_W-1:0] a);
        return {1'b0, a} < (ID_W+1)'(DEPTH);
    endfunction

    t_entry             mem [DEPTH];
    t_entry             r_rd_a;
    t_entry             r_rd_b;
    logic [ID_W-1:0]    r_ia;
    logic [ID_W-1:0]    r_ib;
    logic [DEPTH-1:0]   r_row_vld;
    logic [DEPTH-1:0]   n_row_vld;
    logic               r_fwd_en;
    logic [ID_W-1:0]    r_fwd_addr;
    t_entry             r_fwd_data;
    logic               wr_go;

    assign wr_go = i_commit && i_wr.en && in_rng(i_wr.addr);

    // storage: one write, two registered reads
    always_ff @(posedge i_clk) begin
        if (wr_go) begin
            mem[i_wr.addr[AW-1:0]] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_a <= mem[i_rd_addr_a[AW-1:0]];
            r_rd_b <= mem[i_rd_addr_b[AW-1:0]];
            r_ia   <= i_rd_addr_a;
            r_ib   <= i_rd_addr_b;
        end
    end

    // bypass for a write landing on the same edge as the read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_en <= 1'b0;
        end else if (i_rd_en) begin
            r_fwd_en <= wr_go;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_fwd_addr <= i_wr.addr;
            r_fwd_data <= i_wr.data;
        end
    end

    // row valid flags, cleared at once by reset or a new block;
    // the word's own write lands after the clear
    always_comb begin
        n_row_vld = r_row_vld;
        if (i_clear) begin
            n_row_vld = '0;
        end
        if (wr_go) begin
            n_row_vld[i_wr.addr[AW-1:0]] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
        end else if (i_commit) begin
            r_row_vld <= n_row_vld;
        end
    end

    always_comb begin
        o_ent_a = '0;
        if (i_clear || !in_rng(r_ia)) begin
            o_ent_a = '0;
        end else if (r_fwd_en && r_fwd_addr == r_ia) begin
            o_ent_a = r_fwd_data;
        end else if (r_row_vld[r_ia[AW-1:0]]) begin
            o_ent_a = r_rd_a;
        end
    end

    always_comb begin
        o_ent_b = '0;
        if (i_clear || !in_rng(r_ib)) begin
            o_ent_b = '0;
        end else if (r_fwd_en && r_fwd_addr == r_ib) begin
            o_ent_b = r_fwd_data;
        end else if (r_row_vld[r_ib[AW-1:0]]) begin
            o_ent_b = r_rd_b;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/fot_exec.sv
`timescale 1ns / 1ps
`default_nettype none

module fot_exec
    import fot_pkg::*;
(
    input  wire t_item  i_item,
    input  wire t_entry i_ent_a,
    input  wire t_entry i_ent_b,
    output t_wr         o_wr,
    output t_res        o_res
);

    logic [3:0]      deps;
    logic [3:0]      used;
    logic [ID_W-1:0] pick;
    logic            have;
    logic            ok;
    logic            sel;

    assign deps = cond_flags(i_item.condition);

    // branch: every flag read must carry the same valid origin
    always_comb begin
        used = '0;
        pick = '0;
        have = 1'b0;
        for (int f = 0; f < NFLAGS; f++) begin
            used[f] = deps[NFLAGS-1-f];
        end
        for (int f = 0; f < NFLAGS; f++) begin
            if (used[f] && !have) begin
                pick = i_ent_a.org[f];
                have = 1'b1;
            end
        end
        ok = (used != '0);
        for (int f = 0; f < NFLAGS; f++) begin
            if (used[f] && (!i_ent_a.vld[f] || i_ent_a.org[f] != pick)) begin
                ok = 1'b0;
            end
        end
    end

    always_comb begin
        o_wr      = '0;
        o_wr.addr = i_item.result_value;
        o_res     = '0;
        sel       = 1'b0;
        case (i_item.operation)
            OP_H2N: begin
                o_wr.en       = 1'b1;
                o_wr.data.vld = '1;
                for (int f = 0; f < NFLAGS; f++) begin
                    o_wr.data.org[f] = i_ent_a.vld[f] ? i_ent_a.org[f]
                                                      : i_item.first_value;
                end
            end
            OP_N2H: begin
                o_wr.en   = 1'b1;
                o_wr.data = i_ent_a;
            end
            OP_BRANCH: begin
                if (ok) begin
                    o_res.rewrite   = 1'b1;
                    o_res.old_value = i_item.first_value;
                    o_res.new_value = pick;
                end
            end
            OP_COMBINE: begin
                o_wr.en = i_item.mask_known;
                for (int f = 0; f < NFLAGS; f++) begin
                    sel = i_item.flag_mask[NFLAGS-1-f];
                    o_wr.data.org[f] = sel ? i_ent_b.org[f] : i_ent_a.org[f];
                    o_wr.data.vld[f] = sel ? i_ent_b.vld[f] : i_ent_a.vld[f];
                end
            end
            default: begin
                o_wr.en = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/core/flag_origin_tracker.sv
`timescale 1ns / 1ps
`default_nettype none

// flag_origin_tracker
// Follows, per value id, where each of the N, Z, C and V flags came from, and
// flags a conditional branch whose flags input can be taken straight from the
// one value that produced every flag the condition reads.
// Input channel: i_valid / o_stall plus one port per instruction field. A word
//   is taken on an edge with i_valid high and o_stall low.
// Output channel: o_valid / i_stall plus o_rewrite, o_old_value, o_new_value;
//   one result word for every instruction word, in order.
// Timing: the accepted word sits in the stage register while the origin table
//   is read (two registered read ports); the result is formed and the table
//   written as the word enters the result register. Without receiver stalls,
//   one word per cycle is sustained; the table write port and the bypass from
//   the preceding word keep back-to-back dependent instructions correct.
// Reset (synchronous, active low) empties both stages and marks every table
//   row untracked at once through per-row valid flags; no clearing pass.
//   i_new_block marks every row untracked too, ahead of the word that carries it.
// When the receiver stalls, the result register holds; the stage behind it
//   fills, and o_stall rises only once both are occupied.

module flag_origin_tracker
    import fot_pkg::*;
#(
    parameter int VALUE_COUNT = VALUE_COUNT_D
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_stall,
    input  wire logic            i_new_block,
    input  wire logic [2:0]      i_operation,
    input  wire logic [ID_W-1:0] i_first_value,
    input  wire logic [ID_W-1:0] i_second_value,
    input  wire logic [ID_W-1:0] i_result_value,
    input  wire logic [3:0]      i_condition,
    input  wire logic            i_mask_known,
    input  wire logic [3:0]      i_flag_mask,
    output logic                 o_valid,
    input  wire logic            i_stall,
    output logic                 o_rewrite,
    output logic [ID_W-1:0]      o_old_value,
    output logic [ID_W-1:0]      o_new_value
);

    logic   r_s1_vld;
    t_item  r_s1;
    logic   r_out_vld;
    t_res   r_out;

    logic   out_ld;     // result register free or draining this edge
    logic   s1_adv;     // stage word moves to the result register
    logic   in_acc;     // input word taken
    t_item  in_item;
    t_entry ent_a;
    t_entry ent_b;
    t_wr    wr;
    t_res   res;

    assign out_ld  = !r_out_vld || !i_stall;
    assign s1_adv  = r_s1_vld && out_ld;
    assign in_acc  = i_valid && (!r_s1_vld || s1_adv);
    assign o_stall = r_s1_vld && !out_ld;

    assign in_item = '{
        new_block:    i_new_block,
        operation:    i_operation,
        first_value:  i_first_value,
        second_value: i_second_value,
        result_value: i_result_value,
        condition:    i_condition,
        mask_known:   i_mask_known,
        flag_mask:    i_flag_mask
    };

    // stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (in_acc) begin
            r_s1_vld <= 1'b1;
        end else if (s1_adv) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1 <= in_item;
        end
    end

    // origin table; reads are issued as the word is accepted
    fot_table #(
        .VALUE_COUNT (VALUE_COUNT)
    ) u_table (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_en     (in_acc),
        .i_rd_addr_a (i_first_value),
        .i_rd_addr_b (i_second_value),
        .i_commit    (s1_adv),
        .i_clear     (r_s1.new_block),
        .i_wr        (wr),
        .o_ent_a     (ent_a),
        .o_ent_b     (ent_b)
    );

    fot_exec u_exec (
        .i_item  (r_s1),
        .i_ent_a (ent_a),
        .i_ent_b (ent_b),
        .o_wr    (wr),
        .o_res   (res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_ld) begin
            r_out_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out <= res;
        end
    end

    assign o_valid     = r_out_vld;
    assign o_rewrite   = r_out.rewrite;
    assign o_old_value = r_out.old_value;
    assign o_new_value = r_out.new_value;

    // a result without a rewrite carries no ids
    a_quiet_ids: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_rewrite) |-> (o_old_value == '0 && o_new_value == '0))
        else $error("ids set on a result without rewrite");

    // the input side is never held off while the result register is empty
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_vld |-> !o_stall)
        else $error("stall raised with free result register");

    // an accepted word is in the stage register on the next edge
    a_stage_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_s1_vld)
        else $error("accepted word lost");

    // a word leaving the stage always lands in the result register
    a_result_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv |=> r_out_vld)
        else $error("stage word dropped");

endmodule

`default_nettype wire

// File: test/flag_origin_tracker_checker.sv
`timescale 1ns / 1ps

module flag_origin_tracker_checker
    import fot_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_word_valid,
    input  logic  i_word_stall,
    input  t_item i_word,
    input  logic  i_result_valid,
    input  logic  i_result_stall,
    input  t_res  i_result,
    output int    o_mismatches,
    output int    o_pending
);

    // flags a condition reads, bit3 = N .. bit0 = V
    localparam logic [3:0] READS_N = 4'b1000;
    localparam logic [3:0] READS_Z = 4'b0100;
    localparam logic [3:0] READS_C = 4'b0010;
    localparam logic [3:0] READS_V = 4'b0001;

    t_entry origin_tbl [VALUE_COUNT_D];
    t_res   rewrite_queue [$];
    int     mismatch_count = 0;

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        if (mismatch_count <= 200)
            $display("t=%0t %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    function automatic void clear_origins();
        foreach (origin_tbl[i]) origin_tbl[i] = '0;
    endfunction

    function automatic logic [3:0] flags_read_by(input logic [3:0] cc);
        logic [3:0] rd;
        case (cc)
            CC_EQ, CC_NE: rd = READS_Z;
            CC_CS, CC_CC: rd = READS_C;
            CC_MI, CC_PL: rd = READS_N;
            CC_VS, CC_VC: rd = READS_V;
            CC_HI, CC_LS: rd = READS_Z | READS_C;
            CC_GE, CC_LT: rd = READS_N | READS_V;
            CC_GT, CC_LE: rd = READS_N | READS_Z | READS_V;
            default:      rd = '0;   // AL and the never code
        endcase
        return rd;
    endfunction

    // Updates the origin table for one word and returns the rewrite it should cause.
    function automatic t_res trace_word(input t_item w);
        t_res            res;
        t_entry          src;
        t_entry          rhs;
        t_entry          mix;
        logic [3:0]      used;
        logic            ok;
        logic            have;
        logic            sel;
        logic [ID_W-1:0] pick;
        int              f;

        res = '0;
        if (w.new_block)
            clear_origins();
        // both sources read before the result row is written
        src = origin_tbl[w.first_value];
        rhs = origin_tbl[w.second_value];
        case (w.operation)
            OP_H2N: begin
                for (f = 0; f < NFLAGS; f++)
                    if (!src.vld[f])
                        src.org[f] = w.first_value;
                src.vld = '1;
                origin_tbl[w.result_value] = src;
            end
            OP_N2H: begin
                origin_tbl[w.result_value] = src;
            end
            OP_BRANCH: begin
                used = flags_read_by(w.condition);
                ok   = (used != '0);
                have = 1'b0;
                pick = '0;
                for (f = 0; f < NFLAGS; f++) begin
                    if (used[3-f]) begin
                        if (!src.vld[f]) begin
                            ok = 1'b0;
                        end else if (!have) begin
                            pick = src.org[f];
                            have = 1'b1;
                        end else if (src.org[f] != pick) begin
                            ok = 1'b0;
                        end
                    end
                end
                if (ok && have) begin
                    res.rewrite   = 1'b1;
                    res.old_value = w.first_value;
                    res.new_value = pick;
                end
            end
            OP_COMBINE: begin
                if (w.mask_known) begin
                    for (f = 0; f < NFLAGS; f++) begin
                        sel        = w.flag_mask[3-f];
                        mix.org[f] = sel ? rhs.org[f] : src.org[f];
                        mix.vld[f] = sel ? rhs.vld[f] : src.vld[f];
                    end
                    origin_tbl[w.result_value] = mix;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_res want;
        if (!i_rst_n) begin
            clear_origins();
            rewrite_queue.delete();
        end else begin
            if (i_word_valid && !i_word_stall)
                rewrite_queue.push_back(trace_word(i_word));
            if (i_result_valid && !i_result_stall) begin
                if (rewrite_queue.size() == 0) begin
                    report_mismatch("result word with none outstanding",
                                    i_result.rewrite, 0);
                end else begin
                    want = rewrite_queue.pop_front();
                    if (i_result.rewrite !== want.rewrite)
                        report_mismatch("rewrite", i_result.rewrite, want.rewrite);
                    if (i_result.old_value !== want.old_value)
                        report_mismatch("old_value", i_result.old_value, want.old_value);
                    if (i_result.new_value !== want.new_value)
                        report_mismatch("new_value", i_result.new_value, want.new_value);
                end
            end
        end
        o_mismatches <= mismatch_count;
        o_pending    <= rewrite_queue.size();
    end

endmodule

// File: test/tb_flag_origin_tracker.sv
`timescale 1ns / 1ps

// Stimulus and verdict only; prediction and comparison live in the checker.
module tb_flag_origin_tracker;
    import fot_pkg::*;

    // condition codes the package leaves unnamed: always and never, neither of which reads a flag
    localparam logic [3:0] CC_AL = 4'd14;
    localparam logic [3:0] CC_NV = 4'd15;

    // operation codes with no meaning: lowest and highest of the unused range
    localparam logic [2:0] OP_UNUSED_LO = 3'd5;
    localparam logic [2:0] OP_UNUSED_HI = 3'd7;

    localparam int PHASE_WORDS = 200;
    localparam int POOL_SIZE   = 8;

    logic            i_clk;
    logic            i_rst_n;
    logic            i_valid;
    logic            i_stall;
    t_item           word_q;       // instruction word presented on the input ports
    logic            o_stall;
    logic            o_valid;
    logic            o_rewrite;
    logic [ID_W-1:0] o_old_value;
    logic [ID_W-1:0] o_new_value;
    t_res            result_w;

    int              mismatches;
    int              pending;
    int              send_idle_pct;   // chance in 100 of an idle cycle before a word
    int              stall_pct;       // chance in 100 of a receiver stall cycle
    int              hold_left;       // long receiver hold-off, run down by the receiver
    logic [ID_W-1:0] id_pool [POOL_SIZE];

    assign result_w = {o_rewrite, o_old_value, o_new_value};

    flag_origin_tracker DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_new_block    (word_q.new_block),
        .i_operation    (word_q.operation),
        .i_first_value  (word_q.first_value),
        .i_second_value (word_q.second_value),
        .i_result_value (word_q.result_value),
        .i_condition    (word_q.condition),
        .i_mask_known   (word_q.mask_known),
        .i_flag_mask    (word_q.flag_mask),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_rewrite      (o_rewrite),
        .o_old_value    (o_old_value),
        .o_new_value    (o_new_value)
    );

    flag_origin_tracker_checker u_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_word_valid   (i_valid),
        .i_word_stall   (o_stall),
        .i_word         (word_q),
        .i_result_valid (o_valid),
        .i_result_stall (i_stall),
        .i_result       (result_w),
        .o_mismatches   (mismatches),
        .o_pending      (pending)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // Hard stop well beyond the slowest legal run.
    initial begin
        #200000;
        $display("Some tests failed");
        $finish;
    end

    // Receiver: random stalls at stall_pct, or a solid hold-off while hold_left
    // is non-zero. One assignment to i_stall per edge.
    initial begin : receiver
        i_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                i_stall <= 1'b1;
                hold_left--;
            end else begin
                i_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    function automatic t_item mk_word(input logic nb, input logic [2:0] op,
                                      input logic [ID_W-1:0] a, input logic [ID_W-1:0] b,
                                      input logic [ID_W-1:0] r, input logic [3:0] cc,
                                      input logic known, input logic [3:0] mask);
        t_item w;
        w.new_block    = nb;
        w.operation    = op;
        w.first_value  = a;
        w.second_value = b;
        w.result_value = r;
        w.condition    = cc;
        w.mask_known   = known;
        w.flag_mask    = mask;
        return w;
    endfunction

    // Ids mostly come from a small pool so that branches find tracked rows;
    // the odd one spans the whole id range.
    function automatic logic [ID_W-1:0] pick_id();
        if ($urandom_range(99) < 90)
            return id_pool[$urandom_range(POOL_SIZE-1)];
        return ID_W'($urandom_range(ID_RANGE-1));
    endfunction

    function automatic t_item random_word();
        t_item w;
        int    roll;
        w.new_block    = ($urandom_range(99) < 3);
        w.first_value  = pick_id();
        w.second_value = pick_id();
        w.result_value = pick_id();
        w.condition    = 4'($urandom_range(15));
        w.mask_known   = ($urandom_range(99) < 85);
        w.flag_mask    = 4'($urandom_range(15));
        roll = $urandom_range(99);
        if (roll < 28)
            w.operation = OP_H2N;
        else if (roll < 40)
            w.operation = OP_N2H;
        else if (roll < 65)
            w.operation = OP_COMBINE;
        else if (roll < 95)
            w.operation = OP_BRANCH;
        else
            w.operation = 3'($urandom_range(7));   // any code, none and the unused ones included
        return w;
    endfunction

    // Offer one word after an optional idle gap; returns on the edge that takes it.
    // i_valid is left high so a following word goes out back to back.
    task automatic send_word(input t_item w);
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_valid <= 1'b1;
        word_q  <= w;
        do @(posedge i_clk); while (o_stall);
    endtask

    // Stop offering and wait until every outstanding result word is back.
    // The first edge lets the last accepted word reach the checker's count.
    task automatic drain_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    initial begin : stimulus
        int ph;

        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        word_q        = '0;
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_left     = 0;
        foreach (id_pool[i]) id_pool[i] = '0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // -------- directed part --------
        // branch on an untracked row, with a block start on the same word
        send_word(mk_word(1'b1, OP_BRANCH, 8'h00, 8'h00, 8'h00, CC_EQ, 1'b0, 4'h0));
        // convert from an untracked source: every flag takes the source id
        send_word(mk_word(1'b0, OP_H2N, 8'hFF, 8'h00, 8'h00, CC_EQ, 1'b0, 4'h0));
        send_word(mk_word(1'b0, OP_BRANCH, 8'h00, 8'h00, 8'h00, CC_GT, 1'b0, 4'h0));
        send_word(mk_word(1'b0, OP_N2H, 8'h00, 8'h00, 8'hFF, CC_EQ, 1'b0, 4'h0));
        send_word(mk_word(1'b0, OP_BRANCH, 8'hFF, 8'h00, 8'h00, CC_LE, 1'b0, 4'h0));
        // two distinct origins merged by a known mask: N and C from the right
        send_word(mk_word(1'b0, OP_H2N, 8'h10, 8'h00, 8'h20, CC_EQ, 1'b0, 4'h0));
        send_word(mk_word(1'b0, OP_H2N, 8'h30, 8'h00, 8'h40, CC_EQ, 1'b0, 4'h0));
        send_word(mk_word(1'b0, OP_COMBINE, 8'h20, 8'h40, 8'h50, CC_EQ, 1'b1, 4'b1010));
        // single-flag conditions rewrite; mixed ones see two origins and do not
        send_word(mk_word(1'b0, OP_BRANCH, 8'h50, 8'h00, 8'h00, CC_MI, 1'b0, 4'h0));
        send_word(mk_word(1'b0, OP_BRANCH, 8'h50, 8'h00, 8'h00, CC_EQ, 1'b0, 4'h0));
        send_word(mk_word(1'b0, OP_BRANCH, 8'h50, 8'h00, 8'h00, CC_CS, 1'b0, 4'h0));
        send_word(mk_word(1'b0, OP_BRANCH, 8'h50, 8'h00, 8'h00, CC_VC, 1'b0, 4'h0));
        send_word(mk_word(1'b0, OP_BRANCH, 8'h50, 8'h00, 8'h00, CC_HI, 1'b0, 4'h0));
        send_word(mk_word(1'b0, OP_BRANCH, 8'h50, 8'h00, 8'h00, CC_GE, 1'b0, 4'h0));
        // conditions that read no flags
        send_word(mk_word(1'b0, OP_BRANCH, 8'h50, 8'h00, 8'h00, CC_AL, 1'b0, 4'h0));
        send_word(mk_word(1'b0, OP_BRANCH, 8'h50, 8'h00, 8'h00, CC_NV, 1'b0, 4'h0));
        // unknown mask leaves the row alone; all-clear mask takes the left side
        send_word(mk_word(1'b0, OP_COMBINE, 8'h40, 8'h20, 8'h50, CC_EQ, 1'b0, 4'hF));
        send_word(mk_word(1'b0, OP_COMBINE, 8'h40, 8'h20, 8'h50, CC_EQ, 1'b1, 4'h0));
        send_word(mk_word(1'b0, OP_BRANCH, 8'h50, 8'h00, 8'h00, CC_GT, 1'b0, 4'h0));
        // result id equal to the source id
        send_word(mk_word(1'b0, OP_H2N, 8'h77, 8'h00, 8'h77, CC_EQ, 1'b0, 4'h0));
        // unused operation codes with most other fields at full scale: no effect
        send_word(mk_word(1'b0, OP_UNUSED_LO, 8'hFF, 8'hFF, 8'h77, CC_NV, 1'b1, 4'hF));
        send_word(mk_word(1'b0, OP_UNUSED_HI, 8'hFF, 8'hFF, 8'hFF, CC_NV, 1'b1, 4'hF));
        // all-set mask, right operand equal to the result
        send_word(mk_word(1'b0, OP_COMBINE, 8'h50, 8'h77, 8'h77, CC_EQ, 1'b1, 4'hF));
        send_word(mk_word(1'b0, OP_BRANCH, 8'h77, 8'h00, 8'h00, CC_LS, 1'b0, 4'h0));
        // after a block start: combine of untracked rows, then a partly tracked row
        send_word(mk_word(1'b1, OP_COMBINE, 8'h00, 8'hFF, 8'hAA, CC_EQ, 1'b1, 4'b0110));
        send_word(mk_word(1'b0, OP_H2N, 8'hAA, 8'h00, 8'h55, CC_EQ, 1'b0, 4'h0));
        send_word(mk_word(1'b0, OP_COMBINE, 8'h55, 8'h66, 8'h55, CC_EQ, 1'b1, 4'b1000));
        send_word(mk_word(1'b0, OP_BRANCH, 8'h55, 8'h00, 8'h00, CC_PL, 1'b0, 4'h0));
        send_word(mk_word(1'b0, OP_BRANCH, 8'h55, 8'h00, 8'h00, CC_EQ, 1'b0, 4'h0));
        drain_results();

        // -------- random part, one idling profile per phase --------
        for (ph = 0; ph < 4; ph++) begin
            case (ph)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 85; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 85; end
                default: begin send_idle_pct = 36; stall_pct = 36; end
            endcase
            foreach (id_pool[i]) id_pool[i] = ID_W'($urandom_range(ID_RANGE-1));
            repeat (PHASE_WORDS) send_word(random_word());
            drain_results();

            if (ph == 0) begin
                // long receiver hold-off while words keep coming: the block
                // backs up and must raise o_stall, then empties in order
                hold_left = 64;
                repeat (40) send_word(random_word());
                drain_results();
            end
        end

        // allow for any stray word after the last expected one
        repeat (8) @(posedge i_clk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
